FILE: hdl/cimc_pkg.sv
// shared constants, types and helper functions for the cyclic ideal minimality check
// no dependencies; imported by cimc_engine and cyclic_ideal_minimal_check_core
`timescale 1ns / 1ps
`default_nettype none

package cimc_pkg;

  // word width of a candidate and largest usable cyclic length
  localparam int DATA_W = 16;
  localparam int MAX_N  = 16;
  localparam int LEN_W  = 5;
  localparam int IDX_W  = $clog2(MAX_N);

  // register map
  localparam logic REG_CODE_LENGTH = 1'b0;
  localparam logic [LEN_W-1:0] CODE_LENGTH_RST = LEN_W'(16);

  // result word handed from the engine to the output register
  typedef struct packed {
    logic [DATA_W-1:0] generator;
    logic              is_minimal;
  } res_t;

  // clamp the programmed length into 2..MAX_N
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] cl);
    logic [LEN_W-1:0] len;
    len = cl;
    if (cl < LEN_W'(2)) len = LEN_W'(2);
    if (cl > LEN_W'(MAX_N)) len = LEN_W'(MAX_N);
    return len;
  endfunction

  // low len bits set
  function automatic logic [DATA_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W:0] full;
    full = ((DATA_W+1)'(1) << len) - (DATA_W+1)'(1);
    return full[DATA_W-1:0];
  endfunction

  // cyclic rotate left by one within len bits
  function automatic logic [DATA_W-1:0] rot1(input logic [DATA_W-1:0] v,
                                             input logic [LEN_W-1:0] len);
    logic [IDX_W-1:0] top;
    top = IDX_W'(len - LEN_W'(1));
    return ((v << 1) & len_mask(len)) | DATA_W'(v[top]);
  endfunction

  // index of lowest set bit (value assumed nonzero)
  function automatic logic [IDX_W-1:0] trail_zeros(input logic [DATA_W-1:0] v);
    logic [IDX_W-1:0] t;
    t = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i]) t = IDX_W'(i);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cyclic_ideal_minimal_check_core.sv
// top level: config register, input/output handshakes, result register
// depends on cimc_pkg and cimc_engine
//
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// in       | in_valid, in_ready, candidate             | into block
// out      | out_valid, out_ready, generator, is_minimal | out of block
// config   | psel, penable, pwrite, paddr, pwdata, prdata, pready | apb
//
// one word passes through the fold, rotation-table and scan steps in that order;
// the scan loop through the shared xor/compare unit sets how long a word
// takes
// rst is synchronous and returns code_length to 16 and the engine to idle
// in_ready is high only while the engine is idle; a finished word waits in the
// output register so the next word can be taken while out_ready is low
`timescale 1ns / 1ps
`default_nettype none

module cyclic_ideal_minimal_check_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] candidate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      generator,
  output logic             is_minimal,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cimc_pkg::*;

  logic [LEN_W-1:0] code_length;
  logic             eng_idle;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  res_t             out_word;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= CODE_LENGTH_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CODE_LENGTH) begin
      code_length <= pwdata[LEN_W-1:0];
    end
  end

  // register read
  always_comb begin
    unique case (paddr[2])
      REG_CODE_LENGTH: prdata = 32'(code_length);
      default:         prdata = '0;
    endcase
  end

  cimc_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (in_valid && in_ready),
    .start_word (candidate),
    .code_length(code_length),
    .idle       (eng_idle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign in_ready = eng_idle;

  // output register
  assign res_ready = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_word <= res;
  end

  assign generator  = out_word.generator;
  assign is_minimal = out_word.is_minimal;

`ifndef NO_ASSERTIONS
  // a rejected candidate always reports a zero generator
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_minimal |-> generator == '0)
    else $error("non-minimal word with nonzero generator");

  // only one word in the engine at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("engine took a second word while busy");

  // a new result only comes from a busy engine
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a word in work");
`endif

endmodule

`default_nettype wire

FILE: hdl/cimc_engine.sv
// sequencer and shared xor/compare unit that walks the ideal of one candidate
// depends on cimc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cimc_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cimc_pkg::DATA_W-1:0] start_word,
  input  wire logic [cimc_pkg::LEN_W-1:0]  code_length,
  output logic                             idle,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output cimc_pkg::res_t                   res
);
  import cimc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FOLD = 3'd1;
  localparam logic [2:0] ST_ROT  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        state;
  logic [LEN_W-1:0]  len;
  logic [DATA_W-1:0] kval;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] cur;
  logic [DATA_W-1:0] cnt;
  logic [IDX_W-1:0]  ridx;
  logic              minimal;
  logic [DATA_W-1:0] rot_tab [MAX_N];

  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] acc_next;

  assign mask = len_mask(len);

  // one gray-code step: flipping bit t of the multiplier adds x^t * k
  assign acc_next = acc ^ rot_tab[trail_zeros(cnt)];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (start) state <= ST_FOLD;
        ST_FOLD: if ((acc & ~mask) == '0) state <= ST_ROT;
        ST_ROT:  if (ridx == IDX_W'(len - LEN_W'(1))) state <= ST_SCAN;
        ST_SCAN: begin
          if ((acc_next != '0 && acc_next < kval) || cnt == mask) state <= ST_DONE;
        end
        ST_DONE: if (res_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        kval <= start_word;
        acc  <= start_word;
        len  <= eff_len(code_length);
      end
      ST_FOLD: begin
        // fold exponents at or above n down by n
        if ((acc & ~mask) == '0) begin
          cur  <= acc;
          ridx <= '0;
        end else begin
          acc <= (acc & mask) ^ (acc >> len);
        end
      end
      ST_ROT: begin
        // table of x^i * k mod x^n+1
        rot_tab[ridx] <= cur;
        cur           <= rot1(cur, len);
        ridx          <= ridx + IDX_W'(1);
        acc           <= '0;
        cnt           <= DATA_W'(1);
      end
      ST_SCAN: begin
        acc <= acc_next;
        cnt <= cnt + DATA_W'(1);
        if (acc_next != '0 && acc_next < kval) minimal <= 1'b0;
        else if (cnt == mask) minimal <= 1'b1;
      end
      default: ;
    endcase
  end

  assign idle          = (state == ST_IDLE);
  assign res_valid     = (state == ST_DONE);
  assign res.generator = minimal ? kval : '0;
  assign res.is_minimal = minimal;

endmodule

`default_nettype wire
